// File: rtl/core/cmvm_pkg.sv
// Shared types, constants and codes of the complex matrix-vector multiply block.
package cmvm_pkg;

  // Vector length and index widths
  localparam int DIM     = 8;
  localparam int IDX_W   = $clog2(DIM);
  localparam int FIELD_W = 3;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 40;

  // Item modes
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ACC    = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Input word
  typedef struct packed {
    logic [1:0]              mode;
    logic [FIELD_W-1:0]      row;
    logic [FIELD_W-1:0]      col;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;
  } in_t;

  // Output word
  typedef struct packed {
    logic [FIELD_W-1:0]      out_index;
    logic signed [VAL_W-1:0] out_re;
    logic signed [VAL_W-1:0] out_im;
    logic                    last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             load_en;
    logic             mul_en;
    logic             acc_en;
    logic             emit_en;
    logic [IDX_W-1:0] emit_idx;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/cmvm_ctrl.sv
// Controller state machine: sequences accumulate and emit steps.
module cmvm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  cmvm_pkg::in_t   in_data_i,
  output logic            in_stall_o,
  input  cmvm_pkg::sts_t  sts_i,
  output cmvm_pkg::cmd_t  cmd_o
);
  import cmvm_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             row_ok, col_ok;

  assign row_ok = 32'(in_data_i.row) < DIM;
  assign col_ok = 32'(in_data_i.col) < DIM;

  // State and emit index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    in_stall_o       = 1'b1;
    cmd_o            = '0;
    cmd_o.emit_idx   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (mode_e'(in_data_i.mode))
            MODE_LOAD: begin
              cmd_o.load_en = row_ok;
            end
            MODE_ACC: begin
              if (row_ok && col_ok) state_d = ST_MUL;
            end
            MODE_FINISH: begin
              idx_d   = '0;
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_EMIT: begin
        // Advance one entry whenever the output register can take it
        if (sts_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          idx_d         = idx_q + 1'b1;
          if (idx_q == IDX_W'(DIM - 1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_en |-> sts_i.out_free)
    else $error("emit issued while output register is busy");

  a_final_emit_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_en && idx_q == IDX_W'(DIM - 1)) |=> state_q == ST_IDLE)
    else $error("controller did not return to idle after last entry");

  a_accept_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (state_q == ST_IDLE && !cmd_o.emit_en && !cmd_o.acc_en))
    else $error("word captured outside idle");
`endif

endmodule

// File: rtl/core/cmvm_datapath.sv
// Datapath: vector store, complex multiplier, accumulators and output register.
module cmvm_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmvm_pkg::in_t   in_data_i,
  input  cmvm_pkg::cmd_t  cmd_i,
  output cmvm_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cmvm_pkg::out_t  out_data_o
);
  import cmvm_pkg::*;

  // Round half up to Q1.14 and saturate
  function automatic logic signed [VAL_W-1:0] to_q14(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] r;
    logic [ACC_W-14:0]     sh;
    logic signed [VAL_W-1:0] res;
    r  = {a[ACC_W-1], a} + (ACC_W + 1)'(8192);
    sh = r[ACC_W:14];
    if (sh[ACC_W-14:VAL_W-1] == '0 || sh[ACC_W-14:VAL_W-1] == '1) begin
      res = sh[VAL_W-1:0];
    end else if (sh[ACC_W-14]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [VAL_W-1:0]  vec_re_q [DIM];
  logic signed [VAL_W-1:0]  vec_im_q [DIM];
  logic signed [ACC_W-1:0]  acc_re_q [DIM];
  logic signed [ACC_W-1:0]  acc_im_q [DIM];
  in_t                      item_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PROD_W:0]   sum_re, sum_im;
  logic signed [ACC_W-1:0]  new_re, new_im;
  logic signed [VAL_W-1:0]  xr, xi, yr, yi;
  logic [IDX_W-1:0]         row_idx, col_idx;
  logic                     out_valid_q;
  out_t                     out_q;

  assign row_idx = item_q.row[IDX_W-1:0];
  assign col_idx = item_q.col[IDX_W-1:0];
  assign xr      = vec_re_q[row_idx];
  assign xi      = vec_im_q[row_idx];

  // Hold the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // Form the four partial products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= xr * item_q.value_re;
      p_ii_q <= xi * item_q.value_im;
      p_ri_q <= xr * item_q.value_im;
      p_ir_q <= xi * item_q.value_re;
    end
  end

  assign sum_re = (PROD_W + 1)'(p_rr_q) - (PROD_W + 1)'(p_ii_q);
  assign sum_im = (PROD_W + 1)'(p_ri_q) + (PROD_W + 1)'(p_ir_q);
  assign new_re = acc_re_q[col_idx] + ACC_W'(sum_re);
  assign new_im = acc_im_q[col_idx] + ACC_W'(sum_im);

  // Round the entry being emitted
  assign yr = to_q14(acc_re_q[cmd_i.emit_idx]);
  assign yi = to_q14(acc_im_q[cmd_i.emit_idx]);

  // Accumulators: add on accumulate, clear on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIM; k++) begin
        acc_re_q[k] <= '0;
        acc_im_q[k] <= '0;
      end
    end else if (cmd_i.acc_en) begin
      acc_re_q[col_idx] <= new_re;
      acc_im_q[col_idx] <= new_im;
    end else if (cmd_i.emit_en) begin
      acc_re_q[cmd_i.emit_idx] <= '0;
      acc_im_q[cmd_i.emit_idx] <= '0;
    end
  end

  // Vector store: load from input, overwrite with result on emit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      vec_re_q[in_data_i.row[IDX_W-1:0]] <= in_data_i.value_re;
      vec_im_q[in_data_i.row[IDX_W-1:0]] <= in_data_i.value_im;
    end else if (cmd_i.emit_en) begin
      vec_re_q[cmd_i.emit_idx] <= yr;
      vec_im_q[cmd_i.emit_idx] <= yi;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      out_q.out_index <= FIELD_W'(cmd_i.emit_idx);
      out_q.out_re    <= yr;
      out_q.out_im    <= yi;
      out_q.last      <= (cmd_i.emit_idx == IDX_W'(DIM - 1));
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// File: rtl/core/complex_matrix_vector_multiply_top.sv
// Top level of the complex matrix-vector multiply block.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one word per
// item: load a vector entry x[row], accumulate x[row]*A[row][col] into
// accumulator col, or finish. Output channel (out_valid_o / out_stall_i /
// out_data_o) carries the result entries y[0..DIM-1], last set on y[DIM-1].
// A word moves when valid is high and stall is low at a rising edge.
// Load and unused-mode items leave the controller idle. An accumulate item
// goes through capture, complex multiply into a product register, then the
// 40-bit add into the accumulator. A finish item moves the controller to its
// emit state, which shows y[0] and then one entry per cycle while the receiver
// does not stall; each emitted entry is rounded, saturated, written back to x
// and its accumulator cleared. The input stays stalled until the run is handed
// to the output register, and the next item is taken while y[DIM-1] may still
// wait there. Reset clears the accumulators, the controller and the output
// valid; the vector store holds nothing defined until loaded.
module complex_matrix_vector_multiply_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cmvm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cmvm_pkg::out_t out_data_o
);
  import cmvm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cmvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmvm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: dv/tb_complex_matrix_vector_multiply_top.sv
// Self-checking testbench of the complex matrix-vector multiply block.
module tb_complex_matrix_vector_multiply_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cmvm_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = DIM + 8;
  localparam int MAX_PRINTS    = 40;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int words_taken    = 0;
  int entries_seen   = 0;
  int finish_runs    = 0;
  int quiet_cycles   = 0;

  // Rows of x written so far; an accumulate only reads these
  logic [DIM-1:0] x_loaded = '0;

  // Predicted vector, accumulators and pending y entries
  logic signed [VAL_W-1:0] x_re   [DIM] = '{default: '0};
  logic signed [VAL_W-1:0] x_im   [DIM] = '{default: '0};
  logic signed [ACC_W-1:0] acc_re [DIM] = '{default: '0};
  logic signed [ACC_W-1:0] acc_im [DIM] = '{default: '0};
  out_t                    expected_y[$];

  complex_matrix_vector_multiply_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Run the clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Round half up to Q1.14 and clamp
  function automatic logic signed [VAL_W-1:0] round_to_q14(input logic signed [ACC_W-1:0] a);
    longint r;
    r = (longint'(a) + 64'sd8192) >>> 14;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[VAL_W-1:0];
  endfunction

  // Advance the predicted state by one accepted word
  task automatic update_product(input in_t w);
    longint prod_re, prod_im, sum_re, sum_im;
    out_t   y;
    case (mode_e'(w.mode))
      MODE_LOAD: begin
        x_re[w.row] = w.value_re;
        x_im[w.row] = w.value_im;
      end
      MODE_ACC: begin
        prod_re = longint'(x_re[w.row]) * longint'(w.value_re)
                - longint'(x_im[w.row]) * longint'(w.value_im);
        prod_im = longint'(x_re[w.row]) * longint'(w.value_im)
                + longint'(x_im[w.row]) * longint'(w.value_re);
        sum_re = longint'(acc_re[w.col]) + prod_re;
        sum_im = longint'(acc_im[w.col]) + prod_im;
        acc_re[w.col] = sum_re[ACC_W-1:0];
        acc_im[w.col] = sum_im[ACC_W-1:0];
      end
      MODE_FINISH: begin
        for (int k = 0; k < DIM; k++) begin
          y.out_index = FIELD_W'(k);
          y.out_re    = round_to_q14(acc_re[k]);
          y.out_im    = round_to_q14(acc_im[k]);
          y.last      = (k == DIM - 1);
          expected_y.push_back(y);
          x_re[k]   = y.out_re;
          x_im[k]   = y.out_im;
          acc_re[k] = '0;
          acc_im[k] = '0;
        end
        finish_runs++;
      end
      default: ;  // unused mode leaves everything as is
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Compare one result word with the oldest pending entry
  task automatic check_entry(input out_t got);
    out_t want;
    entries_seen++;
    if (expected_y.size() == 0) begin
      report_mismatch($sformatf("result word index %0d with nothing pending", got.out_index));
      return;
    end
    want = expected_y.pop_front();
    if (got.out_index !== want.out_index)
      report_mismatch($sformatf("out_index %0d, want %0d", got.out_index, want.out_index));
    if (got.out_re !== want.out_re)
      report_mismatch($sformatf("y[%0d] re %0d, want %0d", want.out_index, got.out_re,
                                want.out_re));
    if (got.out_im !== want.out_im)
      report_mismatch($sformatf("y[%0d] im %0d, want %0d", want.out_index, got.out_im,
                                want.out_im));
    if (got.last !== want.last)
      report_mismatch($sformatf("y[%0d] last %0b, want %0b", want.out_index, got.last,
                                want.last));
  endtask

  // Watch both channels: predict on input, check on output, count quiet cycles
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        update_product(in_data_i);
        words_taken++;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        check_entry(out_data_o);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // End a hung run
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input mode_e m, input logic [FIELD_W-1:0] row,
                           input logic [FIELD_W-1:0] col,
                           input logic signed [VAL_W-1:0] re,
                           input logic signed [VAL_W-1:0] im);
    in_t w;
    w.mode     = m;
    w.row      = row;
    w.col      = col;
    w.value_re = re;
    w.value_im = im;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (m == MODE_LOAD) x_loaded[row] = 1'b1;
    if (m == MODE_FINISH) x_loaded = '1;
  endtask

  // Drop valid and wait until every pending entry has come out
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_y.size() != 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return VAL_W'($urandom_range(8192) - 4096);
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // Extremes, rounding ties, saturation, unused mode, back-to-back finish
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(MODE_LOAD, 0, 0, 16'sh8000, 16'sh8000);
    send_word(MODE_LOAD, 1, 7, 16'sd1, 16'sd0);
    send_word(MODE_LOAD, 2, 0, 16'sh7fff, 16'sh7fff);
    send_word(MODE_LOAD, 3, 0, 16'sd0, 16'sd1);
    send_word(MODE_LOAD, 4, 0, 16'sh7fff, 16'sh8000);
    send_word(MODE_LOAD, 5, 0, 16'sh8000, 16'sh7fff);
    send_word(MODE_LOAD, 6, 0, 16'sd0, 16'sd0);
    send_word(MODE_LOAD, 7, 7, -16'sd1, -16'sd1);
    send_word(MODE_UNUSED, 7, 7, 16'sh7fff, 16'sh8000);
    // Ties: +0.5 lsb rounds up, -0.5 lsb rounds to zero, just below rounds down
    send_word(MODE_ACC, 1, 0, 16'sd8192, 16'sd0);
    send_word(MODE_ACC, 1, 1, -16'sd8192, 16'sd0);
    send_word(MODE_ACC, 1, 2, -16'sd8193, 16'sd0);
    send_word(MODE_ACC, 3, 2, 16'sd8192, 16'sd8192);
    // Drive imaginary parts past both rails and one real part past the upper rail
    send_word(MODE_ACC, 0, 4, 16'sh8000, 16'sh8000);
    send_word(MODE_ACC, 0, 4, 16'sh8000, 16'sh8000);
    send_word(MODE_ACC, 2, 5, 16'sh8000, 16'sh8000);
    send_word(MODE_ACC, 4, 6, 16'sh7fff, 16'sh7fff);
    send_word(MODE_ACC, 5, 7, 16'sh8000, 16'sh7fff);
    send_word(MODE_ACC, 7, 3, -16'sd1, 16'sh7fff);
    send_word(MODE_FINISH, 7, 7, 16'sh7fff, 16'sh7fff);
    send_word(MODE_FINISH, 0, 0, 16'sd0, 16'sd0);
    wait_for_results();
  endtask

  // Push one accumulator past the 40-bit range so it wraps
  task automatic test_accumulator_wrap();
    send_idle_pct  = 0;
    recv_stall_pct = 24;
    send_word(MODE_LOAD, 0, 0, 16'sh8000, 16'sh8000);
    repeat (260) send_word(MODE_ACC, 0, 3, 16'sh8000, 16'sh8000);
    send_word(MODE_ACC, 0, 6, 16'sh7fff, 16'sh8000);
    send_word(MODE_FINISH, 0, 0, 16'sd0, 16'sd0);
    wait_for_results();
  endtask

  // Well-formed load/accumulate/finish traffic with a little noise
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_words);
    int                 sent;
    int                 pick;
    logic [FIELD_W-1:0] r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      r    = FIELD_W'($urandom_range(DIM - 1));
      if (pick < 5) begin
        send_word(MODE_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom), pick_value(),
                  pick_value());
      end else begin
        sent++;
        if (pick < 22 || !x_loaded[r])
          send_word(MODE_LOAD, r, FIELD_W'($urandom), pick_value(), pick_value());
        else if (pick < 88)
          send_word(MODE_ACC, r, FIELD_W'($urandom_range(DIM - 1)), pick_value(),
                    pick_value());
        else
          send_word(MODE_FINISH, FIELD_W'($urandom), FIELD_W'($urandom), pick_value(),
                    pick_value());
      end
    end
    wait_for_results();
  endtask

  // Reset once, then run each test in turn
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_accumulator_wrap();
    test_random_traffic(0, 0, 45);
    test_random_traffic(61, 0, 45);
    test_random_traffic(0, 61, 45);
    test_random_traffic(24, 24, 45);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d input words, %0d finish runs, %0d result words checked.",
             words_taken, finish_runs, entries_seen);
    $display("Covered rounding ties, saturation, accumulator wrap and mixed idle/stall phases.");
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
